>>> hdl/bpc_pkg.sv
// shared types, widths and constants of the barometer compensation core
package bpc_pkg;

    // field widths of the streams
    localparam int RAW_W     = 24;
    localparam int CAL_W     = 16;
    localparam int PRES_W    = 23;
    localparam int TEMP_W    = 20;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // configuration port
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int REG_IDX_W = 3;

    // register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_SENS_BASE        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_BASE      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SENS_TEMP_COEF   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_TEMP_COEF = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REF_TEMPERATURE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_SENS_COEF   = 3'd5;

    // pipeline depth per unit
    localparam int FO_STAGES = 3;
    localparam int SO_STAGES = 2;
    localparam int PR_STAGES = 4;
    localparam int STAGES    = FO_STAGES + SO_STAGES + PR_STAGES;

    // datapath widths
    localparam int DT_W    = 25;          // raw temperature minus reference
    localparam int CPROD_W = 42;          // dt times a calibration word
    localparam int DTSQ_W  = 50;          // dt squared
    localparam int T2_W    = 18;          // dt squared / 2^31
    localparam int TEMP1_W = 21;          // first-order temperature
    localparam int SQIN_W  = 22;          // operands of the correction squares
    localparam int SQ_W    = 38;          // kept bits of the correction squares
    localparam int FO_W    = 40;          // offset and sensitivity
    localparam int SLO_W   = 20;          // low slice of sensitivity for the split multiply
    localparam int PLO_W   = RAW_W + SLO_W;
    localparam int PHI_W   = RAW_W + 1 + FO_W - SLO_W;
    localparam int PROD_W  = PHI_W + SLO_W;
    localparam int Y_W     = 46;          // scaled product minus offset
    localparam int PW_W    = Y_W - 15;    // pressure before saturation

    // temperature breakpoints in hundredths
    localparam logic signed [TEMP1_W-1:0] T_LOW_T1  = 21'sd2000;
    localparam logic signed [TEMP1_W-1:0] T_HIGH_T1 = 21'sd4500;
    localparam logic signed [TEMP1_W-1:0] T_COLD_T1 = -21'sd1500;
    localparam logic signed [SQIN_W-1:0]  T_LOW_SQ  = 22'sd2000;
    localparam logic signed [SQIN_W-1:0]  T_HIGH_SQ = 22'sd4500;
    localparam logic signed [SQIN_W-1:0]  T_COLD_SQ = -22'sd1500;

    // pressure saturation limits
    localparam logic signed [PW_W-1:0] PRES_MAX_C = 31'sd4194303;
    localparam logic signed [PW_W-1:0] PRES_MIN_C = -31'sd4194304;

    // calibration words
    typedef struct packed {
        logic [CAL_W-1:0] sens_base;
        logic [CAL_W-1:0] offset_base;
        logic [CAL_W-1:0] sens_temp_coef;
        logic [CAL_W-1:0] offset_temp_coef;
        logic [CAL_W-1:0] ref_temperature;
        logic [CAL_W-1:0] temp_sens_coef;
    } cal_t;

endpackage

>>> hdl/bpc_regs.sv
// apb register file holding the six calibration words
module bpc_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpc_pkg::APB_AW-1:0]    paddr,
    input  logic [bpc_pkg::APB_DW-1:0]    pwdata,
    output logic [bpc_pkg::APB_DW-1:0]    prdata,
    output bpc_pkg::cal_t                 cal
);

    bpc_pkg::cal_t                   cal_reg, cal_next;
    logic [bpc_pkg::REG_IDX_W-1:0]   reg_idx;
    logic                            wr_en;
    logic [bpc_pkg::CAL_W-1:0]       wr_val;
    logic [bpc_pkg::CAL_W-1:0]       rd_val;

    assign reg_idx = paddr[bpc_pkg::APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign wr_val  = pwdata[bpc_pkg::CAL_W-1:0];

    // write decode
    always_comb begin
        cal_next = cal_reg;
        if (wr_en) begin
            unique case (reg_idx)
                bpc_pkg::REG_SENS_BASE:        cal_next.sens_base        = wr_val;
                bpc_pkg::REG_OFFSET_BASE:      cal_next.offset_base      = wr_val;
                bpc_pkg::REG_SENS_TEMP_COEF:   cal_next.sens_temp_coef   = wr_val;
                bpc_pkg::REG_OFFSET_TEMP_COEF: cal_next.offset_temp_coef = wr_val;
                bpc_pkg::REG_REF_TEMPERATURE:  cal_next.ref_temperature  = wr_val;
                bpc_pkg::REG_TEMP_SENS_COEF:   cal_next.temp_sens_coef   = wr_val;
                default:                       cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            bpc_pkg::REG_SENS_BASE:        rd_val = cal_reg.sens_base;
            bpc_pkg::REG_OFFSET_BASE:      rd_val = cal_reg.offset_base;
            bpc_pkg::REG_SENS_TEMP_COEF:   rd_val = cal_reg.sens_temp_coef;
            bpc_pkg::REG_OFFSET_TEMP_COEF: rd_val = cal_reg.offset_temp_coef;
            bpc_pkg::REG_REF_TEMPERATURE:  rd_val = cal_reg.ref_temperature;
            bpc_pkg::REG_TEMP_SENS_COEF:   rd_val = cal_reg.temp_sens_coef;
            default:                       rd_val = '0;
        endcase
    end

    assign prdata = {{(bpc_pkg::APB_DW-bpc_pkg::CAL_W){1'b0}}, rd_val};
    assign cal    = cal_reg;

endmodule

>>> hdl/bpc_first_order.sv
// first-order stages: temperature difference, calibration products, temp/off/sens
module bpc_first_order (
    input  logic                                  aclk,
    input  logic [bpc_pkg::FO_STAGES-1:0]         stage_en,
    input  logic [bpc_pkg::RAW_W-1:0]             raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0]             raw_temperature,
    input  bpc_pkg::cal_t                         cal,
    output logic signed [bpc_pkg::TEMP1_W-1:0]    temp1,
    output logic [bpc_pkg::T2_W-1:0]              t2,
    output logic signed [bpc_pkg::FO_W-1:0]       off1,
    output logic signed [bpc_pkg::FO_W-1:0]       sens1,
    output logic [bpc_pkg::RAW_W-1:0]             d1
);

    localparam int CW = bpc_pkg::CPROD_W;

    logic signed [bpc_pkg::DT_W-1:0]     dt_reg;
    logic [bpc_pkg::RAW_W-1:0]           d1_s1_reg, d1_s2_reg, d1_s3_reg;
    logic signed [CW-1:0]                c6_prod_reg, c4_prod_reg, c3_prod_reg;
    logic signed [bpc_pkg::DTSQ_W-1:0]   dtsq_reg;
    logic signed [CW-1:0]                c6_adj, c4_adj, c3_adj;
    logic signed [bpc_pkg::TEMP1_W-1:0]  temp1_reg, temp1_next;
    logic [bpc_pkg::T2_W-1:0]            t2_reg, t2_next;
    logic signed [bpc_pkg::FO_W-1:0]     off1_reg, off1_next, sens1_reg, sens1_next;

    // stage 1: temperature difference against the reference word
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            dt_reg    <= $signed({1'b0, raw_temperature})
                       - $signed({1'b0, cal.ref_temperature, 8'h00});
            d1_s1_reg <= raw_pressure;
        end
    end

    // stage 2: products with the calibration words and the square of dt
    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            c6_prod_reg <= CW'(dt_reg) * CW'($signed({1'b0, cal.temp_sens_coef}));
            c4_prod_reg <= CW'(dt_reg) * CW'($signed({1'b0, cal.offset_temp_coef}));
            c3_prod_reg <= CW'(dt_reg) * CW'($signed({1'b0, cal.sens_temp_coef}));
            dtsq_reg    <= bpc_pkg::DTSQ_W'(dt_reg) * bpc_pkg::DTSQ_W'(dt_reg);
            d1_s2_reg   <= d1_s1_reg;
        end
    end

    // stage 3: scale toward zero and add the base terms
    assign c6_adj = c6_prod_reg + $signed({{(CW-23){1'b0}}, {23{c6_prod_reg[CW-1]}}});
    assign c4_adj = c4_prod_reg + $signed({{(CW-7){1'b0}}, {7{c4_prod_reg[CW-1]}}});
    assign c3_adj = c3_prod_reg + $signed({{(CW-8){1'b0}}, {8{c3_prod_reg[CW-1]}}});

    always_comb begin
        temp1_next = bpc_pkg::TEMP1_W'($signed(c6_adj[CW-1:23])) + bpc_pkg::T_LOW_T1;
        t2_next    = dtsq_reg[30+bpc_pkg::T2_W:31];
        off1_next  = bpc_pkg::FO_W'($signed({1'b0, cal.offset_base, 16'h0000}))
                   + bpc_pkg::FO_W'($signed(c4_adj[CW-1:7]));
        sens1_next = bpc_pkg::FO_W'($signed({1'b0, cal.sens_base, 15'h0000}))
                   + bpc_pkg::FO_W'($signed(c3_adj[CW-1:8]));
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            temp1_reg <= temp1_next;
            t2_reg    <= t2_next;
            off1_reg  <= off1_next;
            sens1_reg <= sens1_next;
            d1_s3_reg <= d1_s2_reg;
        end
    end

    assign temp1 = temp1_reg;
    assign t2    = t2_reg;
    assign off1  = off1_reg;
    assign sens1 = sens1_reg;
    assign d1    = d1_s3_reg;

endmodule

>>> hdl/bpc_second_order.sv
// second-order stages: correction squares, range flags, corrected off/sens/temp
module bpc_second_order (
    input  logic                                  aclk,
    input  logic [bpc_pkg::SO_STAGES-1:0]         stage_en,
    input  logic signed [bpc_pkg::TEMP1_W-1:0]    temp1,
    input  logic [bpc_pkg::T2_W-1:0]              t2,
    input  logic signed [bpc_pkg::FO_W-1:0]       off1,
    input  logic signed [bpc_pkg::FO_W-1:0]       sens1,
    input  logic [bpc_pkg::RAW_W-1:0]             d1_in,
    output logic signed [bpc_pkg::FO_W-1:0]       off,
    output logic signed [bpc_pkg::FO_W-1:0]       sens,
    output logic [bpc_pkg::TEMP_W-1:0]            temp,
    output logic [bpc_pkg::RAW_W-1:0]             d1_out
);

    localparam int SW = bpc_pkg::SQIN_W;
    localparam int FW = bpc_pkg::FO_W;

    logic signed [SW-1:0]         temp_ext, dq, de, df, temp_full;
    logic signed [2*SW-1:0]       sq_q_full, sq_e_full, sq_f_full;
    logic [bpc_pkg::T2_W-1:0]     t2_sel;
    logic                         lt_low, gt_high, lt_cold;

    logic [bpc_pkg::SQ_W-1:0]     sq_q_reg, sq_e_reg, sq_f_reg;
    logic                         lt_low_reg, gt_high_reg, lt_cold_reg;
    logic [bpc_pkg::TEMP_W-1:0]   temp_s4_reg, temp_s5_reg;
    logic signed [FW-1:0]         off1_s4_reg, sens1_s4_reg;
    logic [bpc_pkg::RAW_W-1:0]    d1_s4_reg, d1_s5_reg;

    logic [FW-1:0]                off2, seven_q, lo_term, hi_term, cold_term, sens2;
    logic signed [FW-1:0]         off_reg, off_next, sens_reg, sens_next;

    // stage 4: distances from the breakpoints and their squares, range flags, corrected temperature
    always_comb begin
        temp_ext  = SW'(temp1);
        dq        = temp_ext - bpc_pkg::T_LOW_SQ;
        de        = temp_ext - bpc_pkg::T_HIGH_SQ;
        df        = temp_ext - bpc_pkg::T_COLD_SQ;
        sq_q_full = (2*SW)'(dq) * (2*SW)'(dq);
        sq_e_full = (2*SW)'(de) * (2*SW)'(de);
        sq_f_full = (2*SW)'(df) * (2*SW)'(df);
        lt_low    = temp1 < bpc_pkg::T_LOW_T1;
        gt_high   = temp1 > bpc_pkg::T_HIGH_T1;
        lt_cold   = temp1 < bpc_pkg::T_COLD_T1;
        t2_sel    = lt_low ? t2 : '0;
        temp_full = temp_ext - $signed({{(SW-bpc_pkg::T2_W){1'b0}}, t2_sel});
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            sq_q_reg     <= sq_q_full[bpc_pkg::SQ_W-1:0];
            sq_e_reg     <= sq_e_full[bpc_pkg::SQ_W-1:0];
            sq_f_reg     <= sq_f_full[bpc_pkg::SQ_W-1:0];
            lt_low_reg   <= lt_low;
            gt_high_reg  <= gt_high;
            lt_cold_reg  <= lt_cold;
            temp_s4_reg  <= temp_full[bpc_pkg::TEMP_W-1:0];
            off1_s4_reg  <= off1;
            sens1_s4_reg <= sens1;
            d1_s4_reg    <= d1_in;
        end
    end

    // stage 5: second-order offset and sensitivity terms
    always_comb begin
        seven_q   = FW'({sq_q_reg, 3'b000}) - FW'(sq_q_reg);
        lo_term   = seven_q >> 3;
        hi_term   = FW'(sq_e_reg) >> 3;
        cold_term = FW'({sq_f_reg, 1'b0});
        off2      = lt_low_reg ? (FW'({sq_q_reg, 1'b0}) + FW'(sq_q_reg)) : '0;
        priority if (lt_low_reg) begin
            sens2 = lo_term;
        end else if (gt_high_reg) begin
            sens2 = '0 - hi_term;
        end else begin
            sens2 = '0;
        end
        if (lt_cold_reg) begin
            sens2 = sens2 + cold_term;
        end
        off_next  = off1_s4_reg - $signed(off2);
        sens_next = sens1_s4_reg - $signed(sens2);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            off_reg     <= off_next;
            sens_reg    <= sens_next;
            temp_s5_reg <= temp_s4_reg;
            d1_s5_reg   <= d1_s4_reg;
        end
    end

    assign off    = off_reg;
    assign sens   = sens_reg;
    assign temp   = temp_s5_reg;
    assign d1_out = d1_s5_reg;

endmodule

>>> hdl/bpc_pressure.sv
// pressure stages: split multiply, scaling toward zero, offset removal, saturation
module bpc_pressure (
    input  logic                                  aclk,
    input  logic [bpc_pkg::PR_STAGES-1:0]         stage_en,
    input  logic signed [bpc_pkg::FO_W-1:0]       off,
    input  logic signed [bpc_pkg::FO_W-1:0]       sens,
    input  logic [bpc_pkg::TEMP_W-1:0]            temp,
    input  logic [bpc_pkg::RAW_W-1:0]             d1,
    output logic signed [bpc_pkg::PRES_W-1:0]     pressure_centi,
    output logic signed [bpc_pkg::TEMP_W-1:0]     temperature_centi
);

    localparam int FW  = bpc_pkg::FO_W;
    localparam int LW  = bpc_pkg::SLO_W;
    localparam int PW  = bpc_pkg::PROD_W;
    localparam int YW  = bpc_pkg::Y_W;
    localparam int XW  = PW - 21;

    logic [bpc_pkg::PLO_W-1:0]          pp_lo_reg;
    logic signed [bpc_pkg::PHI_W-1:0]   pp_hi_reg;
    logic signed [PW-1:0]               prod_reg, prod_next, prod_adj;
    logic signed [XW-1:0]               x_val;
    logic signed [YW-1:0]               y_reg, y_next, y_adj;
    logic signed [bpc_pkg::PW_W-1:0]    pw_val;
    logic signed [bpc_pkg::PRES_W-1:0]  pres_reg, pres_next;
    logic signed [FW-1:0]               off_s6_reg, off_s7_reg;
    logic [bpc_pkg::TEMP_W-1:0]         temp_s6_reg, temp_s7_reg, temp_s8_reg, temp_s9_reg;

    // stage 6: raw pressure times the two halves of sensitivity
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            pp_lo_reg   <= bpc_pkg::PLO_W'(d1) * bpc_pkg::PLO_W'(sens[LW-1:0]);
            pp_hi_reg   <= bpc_pkg::PHI_W'($signed({1'b0, d1}))
                         * bpc_pkg::PHI_W'($signed(sens[FW-1:LW]));
            off_s6_reg  <= off;
            temp_s6_reg <= temp;
        end
    end

    // stage 7: join the partial products
    assign prod_next = $signed({pp_hi_reg, {LW{1'b0}}})
                     + $signed({{(PW-bpc_pkg::PLO_W){1'b0}}, pp_lo_reg});

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            prod_reg    <= prod_next;
            off_s7_reg  <= off_s6_reg;
            temp_s7_reg <= temp_s6_reg;
        end
    end

    // stage 8: divide by 2^21 toward zero, remove offset
    assign prod_adj = prod_reg + $signed({{(PW-21){1'b0}}, {21{prod_reg[PW-1]}}});
    assign x_val    = $signed(prod_adj[PW-1:21]);
    assign y_next   = YW'(x_val) - YW'(off_s7_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            y_reg       <= y_next;
            temp_s8_reg <= temp_s7_reg;
        end
    end

    // stage 9: divide by 2^15 toward zero and clamp to the field range
    assign y_adj  = y_reg + $signed({{(YW-15){1'b0}}, {15{y_reg[YW-1]}}});
    assign pw_val = $signed(y_adj[YW-1:15]);

    always_comb begin
        priority if (pw_val > bpc_pkg::PRES_MAX_C) begin
            pres_next = bpc_pkg::PRES_MAX_C[bpc_pkg::PRES_W-1:0];
        end else if (pw_val < bpc_pkg::PRES_MIN_C) begin
            pres_next = bpc_pkg::PRES_MIN_C[bpc_pkg::PRES_W-1:0];
        end else begin
            pres_next = pw_val[bpc_pkg::PRES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            pres_reg    <= pres_next;
            temp_s9_reg <= temp_s8_reg;
        end
    end

    assign pressure_centi    = pres_reg;
    assign temperature_centi = $signed(temp_s9_reg);

endmodule

>>> hdl/barometric_pressure_compensation_core.sv
// top level of the barometer compensation core: apb registers, flow control, pipeline
//
// Usage
//   Load the six calibration words over the apb port (word i at byte address 4*i,
//   low 16 bits of pwdata) while no beat is in flight. Then stream raw pairs in on
//   the s_ channel; each input beat yields exactly one result beat on the m_ channel.
//   s_tdata:  [23:0] raw pressure, [47:24] raw temperature
//   m_tdata:  [22:0] pressure in 0.01 mbar (signed, clamped), [42:23] temperature
//             in 0.01 C (signed), upper bits zero
//   Throughput is one beat per cycle while m_tready does not stall the output, set
//   by the nine-stage pipeline whose widest step is the sensitivity multiply split
//   into a 24x20 and a 25x20 partial product.
//   Each stage holds a valid bit and advances when it is empty or the stage after it
//   advances, so bubbles close up and a stalled m_tready backs the pipe up stage by
//   stage; s_tready drops only when all nine stages hold data.
//   Reset (aresetn low, synchronous) empties the pipeline and clears the calibration
//   words to zero. pready is always high.
module barometric_pressure_compensation_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [bpc_pkg::S_TDATA_W-1:0]         s_tdata,   // raw_pressure, raw_temperature
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bpc_pkg::M_TDATA_W-1:0]         m_tdata,   // pressure_centi, temperature_centi
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bpc_pkg::APB_AW-1:0]            paddr,
    input  logic [bpc_pkg::APB_DW-1:0]            pwdata,
    output logic [bpc_pkg::APB_DW-1:0]            prdata,
    output logic                                  pready
);

    localparam int NS = bpc_pkg::STAGES;
    localparam int FS = bpc_pkg::FO_STAGES;
    localparam int SS = bpc_pkg::SO_STAGES;

    bpc_pkg::cal_t                          cal;
    logic [NS-1:0]                          valid_reg, valid_next, stage_ready;

    logic signed [bpc_pkg::TEMP1_W-1:0]     temp1;
    logic [bpc_pkg::T2_W-1:0]               t2;
    logic signed [bpc_pkg::FO_W-1:0]        off1, sens1, off, sens;
    logic [bpc_pkg::RAW_W-1:0]              d1_fo, d1_so;
    logic [bpc_pkg::TEMP_W-1:0]             temp_so;
    logic signed [bpc_pkg::PRES_W-1:0]      pressure_centi;
    logic signed [bpc_pkg::TEMP_W-1:0]      temperature_centi;

    assign pready = 1'b1;

    // calibration registers
    bpc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cal     (cal)
    );

    // per-stage advance: a stage moves when it is empty or its successor moves
    always_comb begin
        stage_ready[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        valid_next[0] = stage_ready[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NS; k++) begin
            valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_ready[0];
    assign m_tvalid = valid_reg[NS-1];

    // datapath
    bpc_first_order u_first (
        .aclk            (aclk),
        .stage_en        (stage_ready[FS-1:0]),
        .raw_pressure    (s_tdata[bpc_pkg::RAW_W-1:0]),
        .raw_temperature (s_tdata[2*bpc_pkg::RAW_W-1:bpc_pkg::RAW_W]),
        .cal             (cal),
        .temp1           (temp1),
        .t2              (t2),
        .off1            (off1),
        .sens1           (sens1),
        .d1              (d1_fo)
    );

    bpc_second_order u_second (
        .aclk     (aclk),
        .stage_en (stage_ready[FS+SS-1:FS]),
        .temp1    (temp1),
        .t2       (t2),
        .off1     (off1),
        .sens1    (sens1),
        .d1_in    (d1_fo),
        .off      (off),
        .sens     (sens),
        .temp     (temp_so),
        .d1_out   (d1_so)
    );

    bpc_pressure u_pressure (
        .aclk              (aclk),
        .stage_en          (stage_ready[NS-1:FS+SS]),
        .off               (off),
        .sens              (sens),
        .temp              (temp_so),
        .d1                (d1_so),
        .pressure_centi    (pressure_centi),
        .temperature_centi (temperature_centi)
    );

    // result beat packing
    assign m_tdata = {{(bpc_pkg::M_TDATA_W - bpc_pkg::PRES_W - bpc_pkg::TEMP_W){1'b0}},
                      temperature_centi, pressure_centi};

    // input is refused only when the whole pipe is full and the output is stalled
    a_full_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the pipeline had room");

    // an empty output stage always makes room for a new beat
    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output stage");

    // a taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !valid_reg[NS-2]) |=> !m_tvalid)
        else $error("result beat repeated after being taken");

endmodule
